/* hw/rtl/bst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Shared types and constants: token kinds, scan modes, keyword progress,
// character codes and the layout of one result item.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Default size of the source buffer in bytes.
  localparam int unsigned BufferBytesDefault = 65536;

  // Field widths of a result item.
  localparam int unsigned KindW   = 3;
  localparam int unsigned StartW  = 16;
  localparam int unsigned LengthW = 17;
  localparam int unsigned ByteW   = 8;

  // Token kinds as they appear on the output.
  typedef enum logic [KindW-1:0] {
    KIND_END     = 3'd0,
    KIND_PLUS    = 3'd1,
    KIND_EQUALS  = 3'd2,
    KIND_LET     = 3'd3,
    KIND_IF      = 3'd4,
    KIND_INTEGER = 3'd5,
    KIND_IDENT   = 3'd6,
    KIND_INVALID = 3'd7
  } kind_e;

  // What kind of token is open while scanning.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_KEYWORD = 2'd1,
    MODE_INTEGER = 2'd2,
    MODE_IDENT   = 2'd3
  } mode_e;

  // How much of a keyword has been matched so far.
  typedef enum logic [2:0] {
    KP_NONE = 3'd0,
    KP_L    = 3'd1,
    KP_LE   = 3'd2,
    KP_I    = 3'd3
  } kw_prog_e;

  // Character codes.
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChEquals = 8'h3D;
  localparam logic [ByteW-1:0] ChUnder  = 8'h5F;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;
  localparam logic [ByteW-1:0] ChLowA   = 8'h61;
  localparam logic [ByteW-1:0] ChLowZ   = 8'h7A;
  localparam logic [ByteW-1:0] ChUpA    = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ    = 8'h5A;
  localparam logic [ByteW-1:0] ChLowL   = 8'h6C;
  localparam logic [ByteW-1:0] ChLowE   = 8'h65;
  localparam logic [ByteW-1:0] ChLowT   = 8'h74;
  localparam logic [ByteW-1:0] ChLowI   = 8'h69;
  localparam logic [ByteW-1:0] ChLowF   = 8'h66;

  // One result item.
  typedef struct packed {
    kind_e              kind;
    logic [StartW-1:0]  start;
    logic [LengthW-1:0] length;
    logic [ByteW-1:0]   bad;
    logic               last;
  } token_t;

  // Byte classes.
  function automatic logic is_digit(input logic [ByteW-1:0] c);
    is_digit = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_word(input logic [ByteW-1:0] c);
    is_word = is_digit(c) || ((c >= ChLowA) && (c <= ChLowZ)) ||
              ((c >= ChUpA) && (c <= ChUpZ)) || (c == ChUnder);
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    is_space = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage : bst_pkg
`default_nettype wire

/* hw/rtl/byte_stream_tokenizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// The tokens that an item causes are written into the result queue when it is accepted.
// Throughput: one item per cycle while items cause at most one token each and out_ready_i
// is held high; the result queue drains one token per cycle, so an item causing two or
// three tokens holds off input until the queue has room for three again.
// Reset clears the scan state, the byte position and the result queue.
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Classifies one source byte per cycle while the result queue has room, updates the
// scan state and pushes the tokens that the byte causes into a four-entry result queue.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer_unit #(
  parameter int unsigned BufferBytes = bst_pkg::BufferBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bst_pkg::ByteW-1:0]    byte_value_i,
  input  wire logic                         is_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bst_pkg::KindW-1:0]         token_kind_o,
  output logic [bst_pkg::StartW-1:0]        token_start_o,
  output logic [bst_pkg::LengthW-1:0]       token_length_o,
  output logic [bst_pkg::ByteW-1:0]         invalid_byte_o,
  output logic                              last_of_run_o
);

  localparam int unsigned IdxW = $clog2(BufferBytes);
  localparam int unsigned PosW = $clog2(BufferBytes + 1);
  localparam int unsigned LW   = ((IdxW > bst_pkg::LengthW) ? IdxW : bst_pkg::LengthW) + 1;

  // Scan state.
  bst_pkg::mode_e    mode_q, mode_d;
  bst_pkg::kw_prog_e kp_q, kp_d;
  logic [IdxW-1:0]   begin_q, begin_d;
  logic [PosW-1:0]   pos_q, pos_d;

  // Result queue.
  bst_pkg::token_t   fifo_q [4];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        count_q;

  logic              in_acc, out_acc;
  bst_pkg::token_t   cand [4];
  logic [3:0]        cand_v;
  logic [1:0]        cand_off [4];
  logic [2:0]        num_tok;

  assign in_ready_o = (count_q <= 3'd1);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_acc    = out_valid_o && out_ready_i;

  // Per-byte classification, state update and token candidates.
  always_comb begin
    logic [bst_pkg::ByteW-1:0] c;
    logic [IdxW-1:0]           idx;
    logic                      used;
    logic [bst_pkg::ByteW-1:0] want;
    logic [LW-1:0]             len_close, len_kw, len_end;
    logic [PosW-1:0]           pos_inc;
    bst_pkg::token_t           blank;

    c   = byte_value_i;
    idx = (pos_q < PosW'(BufferBytes - 1)) ? pos_q[IdxW-1:0] : IdxW'(BufferBytes - 1);
    used = 1'b0;
    blank = '{kind: bst_pkg::KIND_END, start: '0, length: '0, bad: '0, last: 1'b0};
    for (int i = 0; i < 4; i++) begin
      cand[i] = blank;
    end
    cand_v  = 4'b0000;
    mode_d  = mode_q;
    kp_d    = kp_q;
    begin_d = begin_q;

    len_close = LW'(idx) - LW'(begin_q);
    len_kw    = LW'(idx) + LW'(1) - LW'(begin_q);

    case (kp_q)
      bst_pkg::KP_L:  want = bst_pkg::ChLowE;
      bst_pkg::KP_LE: want = bst_pkg::ChLowT;
      default:        want = bst_pkg::ChLowF;
    endcase

    // Continue or close the open token.
    cand[0].start = bst_pkg::StartW'(begin_q);
    unique case (mode_q)
      bst_pkg::MODE_INTEGER: begin
        if (bst_pkg::is_digit(c)) begin
          used = 1'b1;
        end else begin
          cand_v[0]      = 1'b1;
          cand[0].kind   = bst_pkg::KIND_INTEGER;
          cand[0].length = len_close[bst_pkg::LengthW-1:0];
          mode_d = bst_pkg::MODE_IDLE;
          kp_d   = bst_pkg::KP_NONE;
        end
      end
      bst_pkg::MODE_IDENT: begin
        if (bst_pkg::is_word(c)) begin
          used = 1'b1;
        end else begin
          cand_v[0]      = 1'b1;
          cand[0].kind   = bst_pkg::KIND_IDENT;
          cand[0].length = len_close[bst_pkg::LengthW-1:0];
          mode_d = bst_pkg::MODE_IDLE;
          kp_d   = bst_pkg::KP_NONE;
        end
      end
      bst_pkg::MODE_KEYWORD: begin
        if (c == want) begin
          used = 1'b1;
          if (kp_q == bst_pkg::KP_L) begin
            kp_d = bst_pkg::KP_LE;
          end else begin
            cand_v[0]      = 1'b1;
            cand[0].kind   = (kp_q == bst_pkg::KP_LE) ? bst_pkg::KIND_LET : bst_pkg::KIND_IF;
            cand[0].length = len_kw[bst_pkg::LengthW-1:0];
            mode_d = bst_pkg::MODE_IDLE;
            kp_d   = bst_pkg::KP_NONE;
          end
        end else if (bst_pkg::is_word(c)) begin
          used   = 1'b1;
          mode_d = bst_pkg::MODE_IDENT;
          kp_d   = bst_pkg::KP_NONE;
        end else begin
          cand_v[0]      = 1'b1;
          cand[0].kind   = bst_pkg::KIND_IDENT;
          cand[0].length = len_close[bst_pkg::LengthW-1:0];
          mode_d = bst_pkg::MODE_IDLE;
          kp_d   = bst_pkg::KP_NONE;
        end
      end
      default: begin
        mode_d = bst_pkg::MODE_IDLE;
        kp_d   = bst_pkg::KP_NONE;
      end
    endcase

    // A byte not taken by an open token starts a new one.
    cand[1].start  = bst_pkg::StartW'(idx);
    cand[1].length = bst_pkg::LengthW'(1);
    if (!used && !bst_pkg::is_space(c)) begin
      if (c == bst_pkg::ChPlus) begin
        cand_v[1]    = 1'b1;
        cand[1].kind = bst_pkg::KIND_PLUS;
      end else if (c == bst_pkg::ChEquals) begin
        cand_v[1]    = 1'b1;
        cand[1].kind = bst_pkg::KIND_EQUALS;
      end else begin
        begin_d = idx;
        if (c == bst_pkg::ChLowL) begin
          mode_d = bst_pkg::MODE_KEYWORD;
          kp_d   = bst_pkg::KP_L;
        end else if (c == bst_pkg::ChLowI) begin
          mode_d = bst_pkg::MODE_KEYWORD;
          kp_d   = bst_pkg::KP_I;
        end else if (bst_pkg::is_digit(c)) begin
          mode_d = bst_pkg::MODE_INTEGER;
        end else if (bst_pkg::is_word(c)) begin
          mode_d = bst_pkg::MODE_IDENT;
        end else begin
          cand_v[1]    = 1'b1;
          cand[1].kind = bst_pkg::KIND_INVALID;
          cand[1].bad  = c;
        end
      end
    end

    // Byte position saturates at the buffer size.
    pos_inc = pos_q + PosW'(1);
    pos_d   = (pos_q < PosW'(BufferBytes)) ? pos_inc : PosW'(BufferBytes);

    // The last byte closes any open token, emits END and clears the state.
    len_end = LW'(pos_d) - LW'(begin_d);
    cand[2].start  = bst_pkg::StartW'(begin_d);
    cand[2].length = len_end[bst_pkg::LengthW-1:0];
    cand[2].kind   = (mode_d == bst_pkg::MODE_INTEGER) ? bst_pkg::KIND_INTEGER
                                                       : bst_pkg::KIND_IDENT;
    if (is_last_i) begin
      cand_v[2] = (mode_d != bst_pkg::MODE_IDLE);
      cand_v[3] = 1'b1;
      mode_d  = bst_pkg::MODE_IDLE;
      kp_d    = bst_pkg::KP_NONE;
      begin_d = '0;
      pos_d   = '0;
    end

    // Mark the last token of this item.
    if (cand_v[3]) begin
      cand[3].last = 1'b1;
    end else if (cand_v[1]) begin
      cand[1].last = 1'b1;
    end else begin
      cand[0].last = 1'b1;
    end

    // Queue offsets of the candidates that are present.
    cand_off[0] = 2'd0;
    cand_off[1] = 2'(cand_v[0]);
    cand_off[2] = cand_off[1] + 2'(cand_v[1]);
    cand_off[3] = cand_off[2] + 2'(cand_v[2]);
    num_tok = 3'(cand_v[0]) + 3'(cand_v[1]) + 3'(cand_v[2]) + 3'(cand_v[3]);
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bst_pkg::MODE_IDLE;
      kp_q    <= bst_pkg::KP_NONE;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      kp_q    <= kp_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + num_tok[1:0];
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (in_acc ? num_tok : 3'd0) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        if (cand_v[i]) begin
          fifo_q[wr_ptr_q + cand_off[i]] <= cand[i];
        end
      end
    end
  end

  // Output fields from the queue head.
  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign token_start_o  = fifo_q[rd_ptr_q].start;
  assign token_length_o = fifo_q[rd_ptr_q].length;
  assign invalid_byte_o = fifo_q[rd_ptr_q].bad;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;

endmodule : byte_stream_tokenizer_unit
`default_nettype wire
